### rtl/xsr_pkg.sv
// Shared constants and controller/datapath interface types for the xoshiro256+ generator.
package xsr_pkg;

    localparam int WordW = 64;
    localparam int HalfW = WordW / 2;

    localparam logic [WordW-1:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [WordW-1:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [WordW-1:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;

    localparam int NEXT_SHIFT = 17;
    localparam int NEXT_ROT   = 45;
    localparam int MIX_SH_A   = 30;
    localparam int MIX_SH_B   = 27;
    localparam int MIX_SH_C   = 31;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_NEXT,
        OP_LOAD_SEED,
        OP_LOAD_ZERO,
        OP_MIX_A,
        OP_MIX_B,
        OP_MUL,
        OP_STORE,
        OP_FIX
    } dp_op_t;

    // partial products of the low 64 bits of a 64x64 multiply
    typedef enum logic [1:0] {
        PART_LL,
        PART_LH,
        PART_HL
    } mul_part_t;

    typedef struct packed {
        dp_op_t    op;
        logic      mul_b;     // 1: second mixing constant
        mul_part_t mul_part;
        logic [1:0] word_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;       // output register can take an item this cycle
    } dp_status_t;

endpackage

### rtl/xsr_datapath.sv
// Datapath: state words, SplitMix64 accumulator, shared 32x32 multiplier and output register.
module xsr_datapath
    import xsr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  dp_cmd_t          cmd,
    output dp_status_t       status,
    input  logic [WordW-1:0] seed_value,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WordW-1:0] out_word
);

    logic [WordW-1:0] s_reg [4];
    logic [WordW-1:0] acc_reg;
    logic [WordW-1:0] x_reg;
    logic [WordW-1:0] prod_reg;
    logic [WordW-1:0] out_word_reg;
    logic             out_valid_reg;

    logic [WordW-1:0] s0_n, s1_n, s2_n, s3_x;
    logic [WordW-1:0] mul_const;
    logic [HalfW-1:0] mul_a, mul_b;
    logic [WordW-1:0] pp;
    logic [WordW-1:0] pp_aligned;
    logic             all_zero;

    // xoshiro256 update
    always_comb
    begin
        s2_n = s_reg[2] ^ s_reg[0];
        s3_x = s_reg[3] ^ s_reg[1];
        s1_n = s_reg[1] ^ s2_n;
        s0_n = s_reg[0] ^ s3_x;
        s2_n = s2_n ^ (s_reg[1] << NEXT_SHIFT);
    end

    assign mul_const = cmd.mul_b ? MIX_MUL_B : MIX_MUL_A;

    always_comb
    begin
        case (cmd.mul_part)
            PART_LL:
            begin
                mul_a = x_reg[HalfW-1:0];
                mul_b = mul_const[HalfW-1:0];
            end
            PART_LH:
            begin
                mul_a = x_reg[HalfW-1:0];
                mul_b = mul_const[WordW-1:HalfW];
            end
            PART_HL:
            begin
                mul_a = x_reg[WordW-1:HalfW];
                mul_b = mul_const[HalfW-1:0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign pp         = WordW'(mul_a) * WordW'(mul_b);
    assign pp_aligned = (cmd.mul_part == PART_LL) ? pp : {pp[HalfW-1:0], {HalfW{1'b0}}};
    assign all_zero   = ((s_reg[0] | s_reg[1] | s_reg[2] | s_reg[3]) == '0);

    assign status.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_NEXT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_NEXT:
            begin
                out_word_reg <= s_reg[0] + s_reg[3];
                s_reg[0]     <= s0_n;
                s_reg[1]     <= s1_n;
                s_reg[2]     <= s2_n;
                s_reg[3]     <= {s3_x[WordW-NEXT_ROT-1:0], s3_x[WordW-1:WordW-NEXT_ROT]};
            end
            OP_LOAD_SEED:
                acc_reg <= seed_value + GOLDEN_GAMMA;
            OP_LOAD_ZERO:
                acc_reg <= GOLDEN_GAMMA;
            OP_MIX_A:
            begin
                x_reg    <= acc_reg ^ (acc_reg >> MIX_SH_A);
                prod_reg <= '0;
            end
            OP_MIX_B:
            begin
                x_reg    <= prod_reg ^ (prod_reg >> MIX_SH_B);
                prod_reg <= '0;
            end
            OP_MUL:
                prod_reg <= prod_reg + pp_aligned;
            OP_STORE:
            begin
                s_reg[cmd.word_idx] <= prod_reg ^ (prod_reg >> MIX_SH_C);
                acc_reg             <= acc_reg + GOLDEN_GAMMA;
            end
            OP_FIX:
            begin
                if (all_zero)
                    s_reg[0] <= GOLDEN_GAMMA;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

### rtl/xsr_ctrl.sv
// Controller: item acceptance and the SplitMix64 seeding sequence.
module xsr_ctrl
    import xsr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_reseed,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_RESET_SEED,
        ST_IDLE,
        ST_MIX_A,
        ST_MUL_A,
        ST_MIX_B,
        ST_MUL_B,
        ST_STORE,
        ST_FIX
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] idx_reg, idx_next;
    mul_part_t  part_reg, part_next;

    assign in_ready = (state_reg == ST_IDLE) && status.out_free;

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        part_next    = part_reg;
        cmd.op       = OP_IDLE;
        cmd.mul_b    = 1'b0;
        cmd.mul_part = part_reg;
        cmd.word_idx = idx_reg;
        case (state_reg)
            ST_RESET_SEED:
            begin
                cmd.op     = OP_LOAD_ZERO;
                idx_next   = '0;
                state_next = ST_MIX_A;
            end
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    if (in_reseed)
                    begin
                        cmd.op     = OP_LOAD_SEED;
                        idx_next   = '0;
                        state_next = ST_MIX_A;
                    end
                    else
                        cmd.op = OP_NEXT;
                end
            end
            ST_MIX_A:
            begin
                cmd.op     = OP_MIX_A;
                part_next  = PART_LL;
                state_next = ST_MUL_A;
            end
            ST_MUL_A:
            begin
                cmd.op = OP_MUL;
                case (part_reg)
                    PART_LL: part_next = PART_LH;
                    PART_LH: part_next = PART_HL;
                    default: state_next = ST_MIX_B;
                endcase
            end
            ST_MIX_B:
            begin
                cmd.op     = OP_MIX_B;
                cmd.mul_b  = 1'b1;
                part_next  = PART_LL;
                state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                cmd.op    = OP_MUL;
                cmd.mul_b = 1'b1;
                case (part_reg)
                    PART_LL: part_next = PART_LH;
                    PART_LH: part_next = PART_HL;
                    default: state_next = ST_STORE;
                endcase
            end
            ST_STORE:
            begin
                cmd.op = OP_STORE;
                if (idx_reg == 2'd3)
                    state_next = ST_FIX;
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_MIX_A;
                end
            end
            ST_FIX:
            begin
                cmd.op     = OP_FIX;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RESET_SEED;
            idx_reg   <= '0;
            part_reg  <= PART_LL;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            part_reg  <= part_next;
        end
    end

endmodule

### rtl/xoshiro256plus_generator.sv
// Top level of the xoshiro256+ generator with SplitMix64 seeding.
//
// A next item (tuser 0) is taken and its 64-bit word appears in the output
// register the cycle after; next items can follow back to back as long as the
// output side keeps taking words. A reseed item (tuser 1) gives no output word
// and holds the input off until its sequence is done: each of the four state
// words needs a mix, three 32x32 partial products on one shared multiplier, a
// mix, three more partial products and a store, then the all-zero check runs.
// After reset the same sequence runs with seed zero behind one load step, and
// no item is taken before it is done.
module xoshiro256plus_generator
    import xsr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [WordW-1:0] s_tdata,   // [63:0] seed_value
    input  logic             s_tuser,   // [0] cmd
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [WordW-1:0] m_tdata    // [63:0] random_word
);

    dp_cmd_t    cmd;
    dp_status_t status;

    xsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_reseed (s_tuser),
        .in_ready  (s_tready),
        .status    (status),
        .cmd       (cmd)
    );

    xsr_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .seed_value (s_tdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_word   (m_tdata)
    );

endmodule

### dv/xoshiro256plus_generator_tb.sv
// Self-checking testbench for the xoshiro256+ generator: reseed and next items vs. a predictor.
`timescale 1ns / 100ps

module xoshiro256plus_generator_tb
    import xsr_pkg::*;
();

    localparam logic CMD_NEXT = 1'b0;
    localparam logic CMD_SEED = 1'b1;

    localparam int LONG_STALL  = 200;
    localparam int DRAIN_WAIT  = 60;      // a reseed keeps the block busy
    localparam int CYCLE_LIMIT = 600000;

    // Tracks the generator state and the words still owed by the block.
    class word_scoreboard;
        logic [WordW-1:0] gen_words [4];
        logic [WordW-1:0] expected_words [$];
        int mismatches;
        int words_checked;
        int seeds_seen;

        function new();
            mismatches    = 0;
            words_checked = 0;
            seeds_seen    = 0;
            reseed('0);
        endfunction

        // SplitMix64 expansion of the seed into the four state words, with the all-zero fix
        function void reseed(logic [WordW-1:0] seed);
            logic [WordW-1:0] acc;
            logic [WordW-1:0] z;
            int i;
            acc = seed;
            for (i = 0; i < 4; i++)
            begin
                acc = acc + GOLDEN_GAMMA;
                z = acc;
                z = (z ^ (z >> MIX_SH_A)) * MIX_MUL_A;
                z = (z ^ (z >> MIX_SH_B)) * MIX_MUL_B;
                gen_words[i] = z ^ (z >> MIX_SH_C);
            end
            if ((gen_words[0] | gen_words[1] | gen_words[2] | gen_words[3]) == '0)
                gen_words[0] = GOLDEN_GAMMA;
        endfunction

        function logic [WordW-1:0] step_next();
            logic [WordW-1:0] sum;
            logic [WordW-1:0] t;
            sum = gen_words[0] + gen_words[3];
            t = gen_words[1] << NEXT_SHIFT;
            gen_words[2] ^= gen_words[0];
            gen_words[3] ^= gen_words[1];
            gen_words[1] ^= gen_words[2];
            gen_words[0] ^= gen_words[3];
            gen_words[2] ^= t;
            gen_words[3] = (gen_words[3] << NEXT_ROT) | (gen_words[3] >> (WordW - NEXT_ROT));
            return sum;
        endfunction

        function void note_command(logic cmd, logic [WordW-1:0] seed);
            if (cmd == CMD_SEED)
            begin
                reseed(seed);
                seeds_seen++;
            end
            else
                expected_words.push_back(step_next());
        endfunction

        function void check_word(logic [WordW-1:0] got);
            logic [WordW-1:0] want;
            if (expected_words.size() == 0)
            begin
                $display("%0t unexpected word: expected none, got %h", $time, got);
                mismatches++;
            end
            else
            begin
                want = expected_words.pop_front();
                words_checked++;
                if (got !== want)
                begin
                    $display("%0t random_word mismatch: expected %h, got %h", $time, want, got);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [WordW-1:0] s_tdata = '0;
    logic             s_tuser = CMD_NEXT;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [WordW-1:0] m_tdata;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit long_stall_req = 1'b0;

    word_scoreboard board = new();

    xoshiro256plus_generator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("xoshiro256plus_generator_tb: errors");
        $finish;
    end

    // output side: check accepted words, pick tready for the next cycle
    initial
    begin : output_side
        int stall_left;
        stall_left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                board.check_word(m_tdata);
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (long_stall_req)
            begin
                long_stall_req = 1'b0;
                stall_left = LONG_STALL;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_item(input logic cmd, input logic [WordW-1:0] seed);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= seed;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_command(cmd, seed);
    endtask

    // hold the input side until every owed word has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic random_items(input int count);
        logic             cmd;
        logic [WordW-1:0] seed;
        int               pick;
        int               n;
        for (n = 0; n < count; n++)
        begin
            cmd  = ($urandom_range(99) < 4) ? CMD_SEED : CMD_NEXT;
            seed = {$urandom, $urandom};
            pick = $urandom_range(15);
            if (pick == 0)
                seed = '0;
            else if (pick == 1)
                seed = '1;
            send_item(cmd, seed);
        end
    endtask

    initial
    begin : stimulus
        int n;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 25;
        recv_idle_pct = 79;

        // words straight out of the reset seeding; seed field ignored on next
        send_item(CMD_NEXT, '0);
        send_item(CMD_NEXT, '1);
        send_item(CMD_NEXT, 64'h8000_0000_0000_0001);
        send_item(CMD_SEED, '0);
        send_item(CMD_NEXT, '1);
        send_item(CMD_SEED, '1);
        send_item(CMD_NEXT, '0);
        send_item(CMD_NEXT, '0);
        send_item(CMD_SEED, 64'h0000_0000_0000_0001);
        send_item(CMD_NEXT, 64'h5555_5555_5555_5555);
        send_item(CMD_SEED, 64'h8000_0000_0000_0000);
        send_item(CMD_NEXT, 64'hAAAA_AAAA_AAAA_AAAA);
        // first SplitMix64 accumulator lands on zero
        send_item(CMD_SEED, -GOLDEN_GAMMA);
        send_item(CMD_NEXT, '0);
        // back-to-back reseeds, the last one wins
        send_item(CMD_SEED, 64'h0123_4567_89AB_CDEF);
        send_item(CMD_SEED, 64'hFEDC_BA98_7654_3210);
        send_item(CMD_NEXT, '1);
        send_item(CMD_NEXT, '0);
        drain();

        random_items(620);

        // long output stall while the input keeps offering next items
        long_stall_req = 1'b1;
        for (n = 0; n < 24; n++)
            send_item(CMD_NEXT, {$urandom, $urandom});
        drain();

        send_idle_pct = 79;
        recv_idle_pct = 25;
        random_items(650);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_items(700);
        drain();

        repeat (DRAIN_WAIT) @(posedge clk);

        $display("checked %0d random words across %0d reseeds, with input and output gaps,",
                 board.words_checked, board.seeds_seen);
        $display("a long output stall against a busy input, and back-to-back traffic");
        if (board.mismatches == 0 && board.pending() == 0)
            $display("xoshiro256plus_generator_tb: clean");
        else
            $display("xoshiro256plus_generator_tb: errors");
        $finish;
    end

endmodule
